// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the tokenizer design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk outside of reset.
`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/hht_pkg.sv =====
// ----------------------------------------------------------------------------
// HTTP header tokenizer package
// Codes, character constants and shared types of the tokenizer.
// ----------------------------------------------------------------------------
package hht_pkg;

  localparam int KEY_COUNT_BITS_DEF   = 8;
  localparam int VALUE_COUNT_BITS_DEF = 10;

  localparam int CFG_W = 10;
  localparam logic [CFG_W-1:0] MAX_VALUE_RESET = 10'd256;

  localparam logic [7:0] KEY_LEN_CAP   = 8'd255;
  localparam logic [9:0] VALUE_LEN_CAP = 10'd1023;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [2:0] ROLE_SKIP  = 3'd0;
  localparam logic [2:0] ROLE_KEY   = 3'd1;
  localparam logic [2:0] ROLE_VALUE = 3'd2;
  localparam logic [2:0] ROLE_DELIM = 3'd3;
  localparam logic [2:0] ROLE_BODY  = 3'd4;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_LINE  = 2'd1;
  localparam logic [1:0] EV_BLOCK = 2'd2;
  localparam logic [1:0] EV_ERROR = 2'd3;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_EMPTY_KEY = 3'd1;
  localparam logic [2:0] ERR_KEY_BREAK = 3'd2;
  localparam logic [2:0] ERR_NO_SPACE  = 3'd3;
  localparam logic [2:0] ERR_EMPTY_VAL = 3'd4;
  localparam logic [2:0] ERR_TOO_LONG  = 3'd5;
  localparam logic [2:0] ERR_NO_LF     = 3'd6;

  typedef enum logic [3:0] {
    PH_START  = 4'd0,
    PH_KEY    = 4'd1,
    PH_COLON  = 4'd2,
    PH_SPACE  = 4'd3,
    PH_VALUE  = 4'd4,
    PH_CR     = 4'd5,
    PH_LF     = 4'd6,
    PH_END_CR = 4'd7,
    PH_DONE   = 4'd8,
    PH_ERROR  = 4'd9
  } hht_phase_t;

  typedef struct packed {
    logic [2:0] byte_role;
    logic [1:0] event_res;
    logic [7:0] key_length;
    logic [9:0] value_length;
    logic [2:0] error_code;
  } hht_result_t;

endpackage

// ===== design/hht_in_stage.sv =====
// ----------------------------------------------------------------------------
// Tokenizer input stage
// Registers one request from the input channel and releases it when the
// decode stage takes it.
// ----------------------------------------------------------------------------
module hht_in_stage
  import hht_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       start_block,
  input  logic       advance,
  output logic       stage_valid,
  output logic [7:0] stage_byte,
  output logic       stage_start
);

  logic accept;

  // The stage can refill in the same cycle that its request moves on.
  assign in_ready = !stage_valid || advance;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_byte  <= data_byte;
      stage_start <= start_block;
    end
  end

endmodule

// ===== design/hht_step.sv =====
// ----------------------------------------------------------------------------
// Tokenizer decode step
// Classifies one byte against the parser state and forms the next state and
// the result fields.
// ----------------------------------------------------------------------------
module hht_step
  import hht_pkg::*;
#(
  parameter int KEY_COUNT_BITS   = KEY_COUNT_BITS_DEF,
  parameter int VALUE_COUNT_BITS = VALUE_COUNT_BITS_DEF
) (
  input  logic [7:0]                  data_byte,
  input  logic                        start_block,
  input  hht_phase_t                  phase,
  input  logic [KEY_COUNT_BITS-1:0]   key_count,
  input  logic [VALUE_COUNT_BITS-1:0] value_count,
  input  logic [2:0]                  held_error,
  input  logic [CFG_W-1:0]            max_value_bytes,
  output hht_phase_t                  phase_next,
  output logic [KEY_COUNT_BITS-1:0]   key_count_next,
  output logic [VALUE_COUNT_BITS-1:0] value_count_next,
  output logic [2:0]                  held_error_next,
  output hht_result_t                 result
);

  localparam logic [KEY_COUNT_BITS-1:0]   KEY_CAP   = '1;
  localparam logic [VALUE_COUNT_BITS-1:0] VALUE_CAP = '1;
  localparam int CMP_W = (VALUE_COUNT_BITS > CFG_W) ? VALUE_COUNT_BITS : CFG_W;
  localparam int KLW   = (KEY_COUNT_BITS > 8) ? KEY_COUNT_BITS : 8;
  localparam int VLW   = (VALUE_COUNT_BITS > 10) ? VALUE_COUNT_BITS : 10;

  hht_phase_t                  ph0;
  logic [KEY_COUNT_BITS-1:0]   kc0;
  logic [VALUE_COUNT_BITS-1:0] vc0;
  logic [2:0]                  err0;
  logic [VALUE_COUNT_BITS-1:0] vc_inc;
  logic                        too_long;
  logic [2:0]                  role;
  logic [1:0]                  ev;
  logic                        is_cr;
  logic                        is_lf;
  logic                        is_colon;
  logic                        is_space;
  logic [KLW-1:0]              kc_wide;
  logic [VLW-1:0]              vc_wide;

  // A start flag restarts the parser before this byte is looked at.
  assign ph0  = start_block ? PH_START : phase;
  assign kc0  = start_block ? '0 : key_count;
  assign vc0  = start_block ? '0 : value_count;
  assign err0 = start_block ? ERR_NONE : held_error;

  assign is_cr    = (data_byte == CH_CR);
  assign is_lf    = (data_byte == CH_LF);
  assign is_colon = (data_byte == CH_COLON);
  assign is_space = (data_byte == CH_SPACE);

  assign vc_inc   = (vc0 == VALUE_CAP) ? vc0 : vc0 + 1'b1;
  assign too_long = CMP_W'(vc_inc) > CMP_W'(max_value_bytes);

  always_comb begin
    phase_next       = ph0;
    key_count_next   = kc0;
    value_count_next = vc0;
    held_error_next  = err0;
    role             = ROLE_SKIP;
    ev               = EV_NONE;
    unique case (ph0)
      PH_START: begin
        if (is_cr || is_lf) begin
          role = ROLE_SKIP;
        end else if (is_colon) begin
          phase_next      = PH_ERROR;
          held_error_next = ERR_EMPTY_KEY;
          ev              = EV_ERROR;
        end else begin
          phase_next       = PH_KEY;
          key_count_next   = KEY_COUNT_BITS'(1);
          value_count_next = '0;
          role             = ROLE_KEY;
        end
      end
      PH_KEY: begin
        if (is_colon) begin
          phase_next = PH_COLON;
          role       = ROLE_DELIM;
        end else if (is_cr || is_lf) begin
          phase_next      = PH_ERROR;
          held_error_next = ERR_KEY_BREAK;
          ev              = EV_ERROR;
        end else begin
          key_count_next = (kc0 == KEY_CAP) ? kc0 : kc0 + 1'b1;
          role           = ROLE_KEY;
        end
      end
      PH_COLON: begin
        if (is_space) begin
          phase_next = PH_SPACE;
          role       = ROLE_DELIM;
        end else begin
          phase_next      = PH_ERROR;
          held_error_next = ERR_NO_SPACE;
          ev              = EV_ERROR;
        end
      end
      PH_SPACE, PH_VALUE: begin
        if (is_cr) begin
          if (ph0 == PH_SPACE) begin
            phase_next      = PH_ERROR;
            held_error_next = ERR_EMPTY_VAL;
            ev              = EV_ERROR;
          end else begin
            phase_next = PH_CR;
            role       = ROLE_DELIM;
          end
        end else if (too_long) begin
          phase_next      = PH_ERROR;
          held_error_next = ERR_TOO_LONG;
          ev              = EV_ERROR;
        end else begin
          // Any byte other than CR, LF included, belongs to the value.
          value_count_next = vc_inc;
          phase_next       = PH_VALUE;
          role             = ROLE_VALUE;
        end
      end
      PH_CR: begin
        if (is_lf) begin
          phase_next = PH_LF;
          role       = ROLE_DELIM;
          ev         = EV_LINE;
        end else begin
          phase_next      = PH_ERROR;
          held_error_next = ERR_NO_LF;
          ev              = EV_ERROR;
        end
      end
      PH_LF: begin
        if (is_cr) begin
          phase_next = PH_END_CR;
          role       = ROLE_DELIM;
        end else if (is_colon) begin
          phase_next      = PH_ERROR;
          held_error_next = ERR_EMPTY_KEY;
          ev              = EV_ERROR;
        end else if (is_lf) begin
          phase_next      = PH_ERROR;
          held_error_next = ERR_KEY_BREAK;
          ev              = EV_ERROR;
        end else begin
          phase_next       = PH_KEY;
          key_count_next   = KEY_COUNT_BITS'(1);
          value_count_next = '0;
          role             = ROLE_KEY;
        end
      end
      PH_END_CR: begin
        if (is_lf) begin
          phase_next = PH_DONE;
          role       = ROLE_DELIM;
          ev         = EV_BLOCK;
        end else begin
          phase_next      = PH_ERROR;
          held_error_next = ERR_NO_LF;
          ev              = EV_ERROR;
        end
      end
      PH_DONE: begin
        role = ROLE_BODY;
      end
      default: begin
        // Held after an error, and the landing place for unused codes.
        phase_next = PH_ERROR;
        role       = ROLE_SKIP;
      end
    endcase
  end

  assign kc_wide = KLW'(key_count_next);
  assign vc_wide = VLW'(value_count_next);

  assign result.byte_role    = role;
  assign result.event_res    = ev;
  assign result.key_length   = (kc_wide > KLW'(KEY_LEN_CAP)) ? KEY_LEN_CAP : kc_wide[7:0];
  assign result.value_length = (vc_wide > VLW'(VALUE_LEN_CAP)) ? VALUE_LEN_CAP
                                                               : vc_wide[9:0];
  assign result.error_code   = held_error_next;

endmodule

// ===== design/http_header_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// HTTP header tokenizer core
// Tags each byte of a header block and reports finished lines, the end of
// the block and syntax errors.
//
//   Channel   Signals                                    Direction
//   input     in_valid, in_ready, data_byte, start_block  request in
//   output    out_valid, out_ready, byte_role, event_res,
//             key_length, value_length, error_code        result out
//   config    cfg_we, cfg_wdata                           write only
//
// A byte is registered on acceptance and decoded into the result register as
// it moves on from the input register; a stalled output holds it back.
// One byte is taken per cycle while the output is not stalled; the parser
// state updates as a byte moves from the input register into the result register.
// A stalled output holds its result and the input register keeps one more
// request; the input only stalls when both are full.
// Reset is synchronous; no clearing pass follows.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module http_header_tokenizer_core
  import hht_pkg::*;
#(
  parameter int KEY_COUNT_BITS   = KEY_COUNT_BITS_DEF,
  parameter int VALUE_COUNT_BITS = VALUE_COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       data_byte,
  input  logic             start_block,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       byte_role,
  output logic [1:0]       event_res,
  output logic [7:0]       key_length,
  output logic [9:0]       value_length,
  output logic [2:0]       error_code,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic                        s1_valid;
  logic [7:0]                  s1_byte;
  logic                        s1_start;
  logic                        s1_move;
  logic [CFG_W-1:0]            max_value_bytes;
  hht_phase_t                  phase;
  hht_phase_t                  phase_next;
  logic [KEY_COUNT_BITS-1:0]   key_count;
  logic [KEY_COUNT_BITS-1:0]   key_count_next;
  logic [VALUE_COUNT_BITS-1:0] value_count;
  logic [VALUE_COUNT_BITS-1:0] value_count_next;
  logic [2:0]                  held_error;
  logic [2:0]                  held_error_next;
  hht_result_t                 result;
  hht_result_t                 out_reg;

  assign s1_move = s1_valid && (!out_valid || out_ready);

  hht_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .start_block (start_block),
    .advance     (s1_move),
    .stage_valid (s1_valid),
    .stage_byte  (s1_byte),
    .stage_start (s1_start)
  );

  hht_step #(
    .KEY_COUNT_BITS   (KEY_COUNT_BITS),
    .VALUE_COUNT_BITS (VALUE_COUNT_BITS)
  ) u_step (
    .data_byte        (s1_byte),
    .start_block      (s1_start),
    .phase            (phase),
    .key_count        (key_count),
    .value_count      (value_count),
    .held_error       (held_error),
    .max_value_bytes  (max_value_bytes),
    .phase_next       (phase_next),
    .key_count_next   (key_count_next),
    .value_count_next (value_count_next),
    .held_error_next  (held_error_next),
    .result           (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_value_bytes <= MAX_VALUE_RESET;
    end else if (cfg_we) begin
      max_value_bytes <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      key_count   <= '0;
      value_count <= '0;
      held_error  <= ERR_NONE;
    end else if (s1_move) begin
      phase       <= phase_next;
      key_count   <= key_count_next;
      value_count <= value_count_next;
      held_error  <= held_error_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_reg <= result;
    end
  end

  assign byte_role    = out_reg.byte_role;
  assign event_res    = out_reg.event_res;
  assign key_length   = out_reg.key_length;
  assign value_length = out_reg.value_length;
  assign error_code   = out_reg.error_code;

  `ASSERT_CLK_RST(a_error_event_tags, out_valid && event_res == EV_ERROR |-> byte_role == ROLE_SKIP && error_code != ERR_NONE, "error result without skip role or code")
  `ASSERT_CLK_RST(a_held_error_phase, held_error != ERR_NONE |-> phase == PH_ERROR, "held error outside the error phase")
  `ASSERT_CLK_RST(a_done_gives_body, phase == PH_DONE && s1_move && !s1_start |=> byte_role == ROLE_BODY, "byte after block end not tagged as body")
  `ASSERT_CLK(a_stall_only_when_full, !rst && !in_ready |-> s1_valid && out_valid, "input stalled with free space")

endmodule

// ===== dv/http_header_tokenizer_core_tb.sv =====
// ----------------------------------------------------------------------------
// HTTP header tokenizer core testbench
// Feeds header blocks byte by byte through the request channel and checks
// every tagged byte against an in-bench tokenizer, or against the table entry for check rows. A directed table covers
// each error code, the line and block ends, body bytes and the value limit
// extremes. Random phases follow with well-formed blocks, corrupted blocks
// and loose noise under several value limits, with random stalls on both
// channels in all but the last phase.
// ----------------------------------------------------------------------------
module http_header_tokenizer_core_tb
  import hht_pkg::*;
();

  localparam int STALL_LIMIT = 500;
  localparam int PHASE_ITEMS = 90;

  typedef enum logic [1:0] {ROW_BYTE, ROW_CHECK, ROW_CFG} row_kind_t;
  typedef enum int {SEQ_CLEAN, SEQ_BROKEN, SEQ_NOISE} seq_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [7:0]       b;
    logic             s;
    logic [CFG_W-1:0] cfg;
    hht_result_t      want;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] b;
    logic       s;
  } byte_req_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       data_byte = 8'h00;
  logic             start_block = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [2:0]       byte_role;
  logic [1:0]       event_res;
  logic [7:0]       key_length;
  logic [9:0]       value_length;
  logic [2:0]       error_code;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Tokenizer state mirrored by the bench.
  hht_phase_t       tok_phase = PH_START;
  logic [7:0]       tok_key_len = '0;
  logic [9:0]       tok_val_len = '0;
  logic [2:0]       tok_err = ERR_NONE;
  logic [CFG_W-1:0] value_limit = MAX_VALUE_RESET;

  hht_result_t      pending_tags[$];
  stim_row_t        steps[$];
  int unsigned      tally = 0;
  int unsigned      live_items = 0;
  int unsigned      quiet_cycles = 0;
  int               long_left = 0;
  bit               calm = 1'b0;

  http_header_tokenizer_core u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .start_block  (start_block),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .byte_role    (byte_role),
    .event_res    (event_res),
    .key_length   (key_length),
    .value_length (value_length),
    .error_code   (error_code),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic hht_result_t tokenize_byte(logic [7:0] b, logic s);
    logic [2:0] role;
    logic [1:0] ev;
    logic [2:0] fault;
    logic [9:0] nxt;
    role = ROLE_SKIP;
    ev = EV_NONE;
    fault = ERR_NONE;
    if (s) begin
      tok_phase = PH_START;
      tok_key_len = '0;
      tok_val_len = '0;
      tok_err = ERR_NONE;
    end
    case (tok_phase)
      PH_START, PH_LF: begin
        if (tok_phase == PH_LF && b == CH_CR) begin
          role = ROLE_DELIM;
          tok_phase = PH_END_CR;
        end else if (b == CH_COLON) begin
          fault = ERR_EMPTY_KEY;
        end else if (b == CH_CR || b == CH_LF) begin
          // Breaks before the first key are skipped; after a line a bare LF is an error.
          if (tok_phase == PH_LF) fault = ERR_KEY_BREAK;
        end else begin
          tok_key_len = 8'd1;
          tok_val_len = '0;
          tok_phase = PH_KEY;
          role = ROLE_KEY;
        end
      end
      PH_KEY: begin
        if (b == CH_COLON) begin
          role = ROLE_DELIM;
          tok_phase = PH_COLON;
        end else if (b == CH_CR || b == CH_LF) begin
          fault = ERR_KEY_BREAK;
        end else begin
          if (tok_key_len != KEY_LEN_CAP) tok_key_len = tok_key_len + 8'd1;
          role = ROLE_KEY;
        end
      end
      PH_COLON: begin
        if (b == CH_SPACE) begin
          role = ROLE_DELIM;
          tok_phase = PH_SPACE;
        end else begin
          fault = ERR_NO_SPACE;
        end
      end
      PH_SPACE, PH_VALUE: begin
        if (b == CH_CR) begin
          if (tok_phase == PH_SPACE) begin
            fault = ERR_EMPTY_VAL;
          end else begin
            role = ROLE_DELIM;
            tok_phase = PH_CR;
          end
        end else begin
          nxt = (tok_val_len == VALUE_LEN_CAP) ? VALUE_LEN_CAP : tok_val_len + 10'd1;
          if (nxt > value_limit) begin
            fault = ERR_TOO_LONG;
          end else begin
            tok_val_len = nxt;
            role = ROLE_VALUE;
            tok_phase = PH_VALUE;
          end
        end
      end
      PH_CR, PH_END_CR: begin
        if (b == CH_LF) begin
          role = ROLE_DELIM;
          ev = (tok_phase == PH_CR) ? EV_LINE : EV_BLOCK;
          tok_phase = (tok_phase == PH_CR) ? PH_LF : PH_DONE;
        end else begin
          fault = ERR_NO_LF;
        end
      end
      PH_DONE: role = ROLE_BODY;
      default: tok_phase = PH_ERROR;
    endcase
    if (fault != ERR_NONE) begin
      tok_err = fault;
      tok_phase = PH_ERROR;
      role = ROLE_SKIP;
      ev = EV_ERROR;
    end
    return '{role, ev, tok_key_len, tok_val_len, tok_err};
  endfunction

  function automatic void put_byte(logic [7:0] b, logic s);
    steps.push_back('{ROW_BYTE, b, s, '0, '0});
  endfunction

  function automatic void put_check(logic [7:0] b, logic s, logic [2:0] role, logic [1:0] ev,
                                    logic [7:0] k, logic [9:0] v, logic [2:0] e);
    steps.push_back('{ROW_CHECK, b, s, '0, '{role, ev, k, v, e}});
  endfunction

  function automatic void put_cfg(logic [CFG_W-1:0] v);
    steps.push_back('{ROW_CFG, 8'h00, 1'b0, v, '0});
  endfunction

  function automatic logic [7:0] key_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_LF || c == CH_COLON);
    return c;
  endfunction

  function automatic logic [7:0] value_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_CR);
    return c;
  endfunction

  function automatic logic [7:0] odd_char();
    case ($urandom_range(0, 4))
      0: return CH_CR;
      1: return CH_LF;
      2: return CH_COLON;
      3: return CH_SPACE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int value_len_pick();
    int r;
    r = $urandom_range(0, 19);
    if (value_limit == 0) return 1;
    // Past the counter cap the value count saturates and the limit is never exceeded.
    if (value_limit == VALUE_LEN_CAP && long_left > 0) begin
      long_left--;
      return 1030;
    end
    if (r == 0 && value_limit != VALUE_LEN_CAP) return int'(value_limit) + 1;
    if (r == 1 && value_limit <= 40) return int'(value_limit);
    return $urandom_range(1, (value_limit < 8) ? int'(value_limit) : 8);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic s, input bit typed,
                           input hht_result_t want);
    hht_result_t guess;
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    start_block <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    guess = tokenize_byte(b, s);
    pending_tags.push_back(typed ? want : guess);
    live_items++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_tags.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    value_limit = v;
  endtask

  task automatic send_sequence(input seq_kind_t kind);
    byte_req_t q[$];
    int        klen;
    int        vlen;
    int        pos;
    if (kind == SEQ_NOISE) begin
      repeat ($urandom_range(1, 8)) q.push_back('{odd_char(), $urandom_range(0, 3) == 0});
    end else begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2)) q.push_back('{$urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0});
      repeat ($urandom_range(1, 4)) begin
        klen = ($urandom_range(0, 29) == 0) ? $urandom_range(250, 262) : $urandom_range(1, 6);
        repeat (klen) q.push_back('{key_char(), 1'b0});
        q.push_back('{CH_COLON, 1'b0});
        q.push_back('{CH_SPACE, 1'b0});
        vlen = value_len_pick();
        repeat (vlen) q.push_back('{value_char(), 1'b0});
        q.push_back('{CH_CR, 1'b0});
        q.push_back('{CH_LF, 1'b0});
      end
      q.push_back('{CH_CR, 1'b0});
      q.push_back('{CH_LF, 1'b0});
      repeat ($urandom_range(0, 3)) q.push_back('{8'($urandom_range(0, 255)), 1'b0});
      q[0].s = 1'b1;
      if (kind == SEQ_BROKEN) begin
        pos = $urandom_range(0, q.size() - 1);
        q[pos].b = odd_char();
      end
    end
    foreach (q[i]) send_byte(q[i].b, q[i].s, 1'b0, '0);
  endtask

  task automatic flag_mismatch(input hht_result_t want, input bit orphan);
    tally++;
    if (tally <= 10) begin
      if (orphan)
        $display("unexpected result: role %0d ev %0d key %0d val %0d err %0d",
                 byte_role, event_res, key_length, value_length, error_code);
      else
        $display({"tag mismatch: want role %0d ev %0d key %0d val %0d err %0d, ",
                  "got role %0d ev %0d key %0d val %0d err %0d"},
                 want.byte_role, want.event_res, want.key_length, want.value_length,
                 want.error_code, byte_role, event_res, key_length, value_length,
                 error_code);
    end
  endtask

  always @(posedge clk) begin
    hht_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_tags.size() == 0) begin
        flag_mismatch('0, 1'b1);
      end else begin
        want = pending_tags.pop_front();
        if (byte_role !== want.byte_role || event_res !== want.event_res ||
            key_length !== want.key_length || value_length !== want.value_length ||
            error_code !== want.error_code)
          flag_mismatch(want, 1'b0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    forever begin
      if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  initial begin
    int plan [6];
    int lim;
    int r;
    plan = '{1023, 0, 1, -1, 256, -1};

    // Leading break, colon at line start, held bytes, then each key, colon and empty value error.
    put_check(CH_CR, 1, ROLE_SKIP, EV_NONE, 0, 0, ERR_NONE);
    put_check(CH_COLON, 0, ROLE_SKIP, EV_ERROR, 0, 0, ERR_EMPTY_KEY);
    put_check(8'h00, 0, ROLE_SKIP, EV_NONE, 0, 0, ERR_EMPTY_KEY);
    put_byte("k", 1);
    put_check(CH_LF, 0, ROLE_SKIP, EV_ERROR, 1, 0, ERR_KEY_BREAK);
    put_byte(8'hFF, 1);
    put_byte(CH_COLON, 0);
    put_check("q", 0, ROLE_SKIP, EV_ERROR, 1, 0, ERR_NO_SPACE);
    put_byte("k", 1);
    put_byte(CH_COLON, 0);
    put_byte(CH_SPACE, 0);
    put_check(CH_CR, 0, ROLE_SKIP, EV_ERROR, 1, 0, ERR_EMPTY_VAL);
    // A value may hold LF; a bare LF where the next key should start is an error.
    put_byte("A", 1);
    put_byte(CH_COLON, 0);
    put_byte(CH_SPACE, 0);
    put_byte(CH_LF, 0);
    put_byte(8'hFF, 0);
    put_byte(CH_CR, 0);
    put_check(CH_LF, 0, ROLE_DELIM, EV_LINE, 1, 2, ERR_NONE);
    put_check(CH_LF, 0, ROLE_SKIP, EV_ERROR, 1, 2, ERR_KEY_BREAK);
    // Two lines, the blank line and a body byte.
    put_byte("A", 1);
    put_byte(CH_COLON, 0);
    put_byte(CH_SPACE, 0);
    put_byte("v", 0);
    put_byte(CH_CR, 0);
    put_byte(CH_LF, 0);
    put_check("C", 0, ROLE_KEY, EV_NONE, 1, 0, ERR_NONE);
    put_byte(CH_COLON, 0);
    put_byte(CH_SPACE, 0);
    put_byte("w", 0);
    put_byte(CH_CR, 0);
    put_byte(CH_LF, 0);
    put_byte(CH_CR, 0);
    put_check(CH_LF, 0, ROLE_DELIM, EV_BLOCK, 1, 1, ERR_NONE);
    put_check(8'hFF, 0, ROLE_BODY, EV_NONE, 1, 1, ERR_NONE);
    // A zero limit rejects the first value byte.
    put_cfg(0);
    put_byte("k", 1);
    put_byte(CH_COLON, 0);
    put_byte(CH_SPACE, 0);
    put_check("a", 0, ROLE_SKIP, EV_ERROR, 1, 0, ERR_TOO_LONG);
    put_cfg(1);
    put_byte("k", 1);
    put_byte(CH_COLON, 0);
    put_byte(CH_SPACE, 0);
    put_byte("a", 0);
    put_byte(CH_CR, 0);
    put_check("z", 0, ROLE_SKIP, EV_ERROR, 1, 1, ERR_NO_LF);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (steps[i]) begin
      if (steps[i].kind == ROW_CFG)
        write_limit(steps[i].cfg);
      else
        send_byte(steps[i].b, steps[i].s, steps[i].kind == ROW_CHECK, steps[i].want);
    end

    foreach (plan[p]) begin
      lim = (plan[p] < 0) ? $urandom_range(2, 1022) : plan[p];
      if (p == 5) calm = 1'b1;
      long_left = (lim == 1023) ? 1 : 0;
      write_limit(CFG_W'(lim));
      live_items = 0;
      while (live_items < PHASE_ITEMS) begin
        r = $urandom_range(0, 19);
        send_sequence((r < 15) ? SEQ_CLEAN : (r < 18) ? SEQ_BROKEN : SEQ_NOISE);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (tally == 0 && pending_tags.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/hht_pkg.sv
design/hht_in_stage.sv
design/hht_step.sv
design/http_header_tokenizer_core.sv
dv/http_header_tokenizer_core_tb.sv
